@@ hdl/omwp_pkg.sv @@
// ----------------------------------------------------------------------------
// omwp_pkg
// Shared types and constants of the omni-wheel move planner.
// ----------------------------------------------------------------------------
package omwp_pkg;

  // 0.866025 as unsigned Q0.16
  localparam logic [16:0] COS30 = 17'd56756;
  // 0.1 step in units of 2^-32 step
  localparam logic [31:0] THRESH = 32'd429496730;
  // 1.0 in Q16.8
  localparam logic [23:0] FLOOR_Q8 = 24'd256;
  localparam logic [24:0] SHARE_ONE = 25'h1000000;

  // configuration register indexes
  localparam logic [2:0] REG_XS = 3'd0;
  localparam logic [2:0] REG_YS = 3'd1;
  localparam logic [2:0] REG_SD = 3'd2;
  localparam logic [2:0] REG_DG = 3'd3;
  localparam logic [2:0] REG_G3 = 3'd4;
  localparam logic [2:0] REG_TS = 3'd5;
  localparam logic [2:0] REG_TA = 3'd6;

  // multiplier operations
  localparam logic [3:0] OP_XK = 4'd0;  // xs * cos30
  localparam logic [3:0] OP_XG = 4'd1;  // xs * third wheel gain
  localparam logic [3:0] OP_GY = 4'd2;  // drift gain * ys
  localparam logic [3:0] OP_TX = 4'd3;  // dx * (xs * cos30)
  localparam logic [3:0] OP_T3 = 4'd4;  // dx * (xs * g3)
  localparam logic [3:0] OP_DY = 4'd5;  // dy * ys
  localparam logic [3:0] OP_DD = 4'd6;  // |dx| * (dg * ys)
  localparam logic [3:0] OP_DR = 4'd7;  // dr * sd
  localparam logic [3:0] OP_SP = 4'd8;  // share * top speed
  localparam logic [3:0] OP_AC = 4'd9;  // share * top accel

  typedef struct packed {
    logic       load;
    logic       clr;
    logic       mul_go;
    logic [3:0] mul_op;
    logic [1:0] wheel;
    logic       find_max;
    logic       div_start;
    logic       div_step;
    logic       div_store;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic below;
  } sts_t;

endpackage

@@ hdl/omni_wheel_move_planner.sv @@
// ----------------------------------------------------------------------------
// omni_wheel_move_planner
// Three-wheel omni inverse kinematics: target pose in, wheel steps and
// scaled speed/acceleration out.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   in      | in_valid/in_ready, target_*     | input
//   out     | out_valid/out_ready, wheel*_*,  | output
//           | moved                           |
//   cfg     | cfg_we, cfg_index, cfg_data     | input
//
// Each item makes eight passes through the shared multiplier, then three
// share divisions on the single divider, then six scaling passes. A move
// below threshold skips the divisions and the scaling.
// One item is in flight at a time; the result sits in the output register
// while the next target is taken. Synchronous reset zeroes the pose and
// restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module omni_wheel_move_planner #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] target_x,
  input  logic signed [23:0] target_y,
  input  logic signed [23:0] target_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [24:0] wheel1_steps,
  output logic signed [24:0] wheel2_steps,
  output logic signed [24:0] wheel3_steps,
  output logic [23:0]        wheel1_speed,
  output logic [23:0]        wheel2_speed,
  output logic [23:0]        wheel3_speed,
  output logic [23:0]        wheel1_accel,
  output logic [23:0]        wheel2_accel,
  output logic [23:0]        wheel3_accel,
  output logic               moved,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  omwp_pkg::cmd_t cmd;
  omwp_pkg::sts_t sts;

  omwp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  omwp_datapath #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .target_x       (target_x),
    .target_y       (target_y),
    .target_heading (target_heading),
    .wheel1_steps   (wheel1_steps),
    .wheel2_steps   (wheel2_steps),
    .wheel3_steps   (wheel3_steps),
    .wheel1_speed   (wheel1_speed),
    .wheel2_speed   (wheel2_speed),
    .wheel3_speed   (wheel3_speed),
    .wheel1_accel   (wheel1_accel),
    .wheel2_accel   (wheel2_accel),
    .wheel3_accel   (wheel3_accel),
    .moved          (moved)
  );

endmodule

@@ hdl/omwp_ctrl.sv @@
// ----------------------------------------------------------------------------
// omwp_ctrl
// Sequencer: multiply schedule, max search, share division, scaling, output.
// ----------------------------------------------------------------------------
module omwp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  omwp_pkg::sts_t sts,
  output omwp_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_DRAIN  = 4'd2;
  localparam logic [3:0] S_MAX    = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_DIVI   = 4'd5;
  localparam logic [3:0] S_DIVS   = 4'd6;
  localparam logic [3:0] S_DIVQ   = 4'd7;
  localparam logic [3:0] S_SCALE  = 4'd8;
  localparam logic [3:0] S_SDRAIN = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] wheel, wheel_next;
  logic       out_load;

  assign in_ready = (state == S_IDLE);
  assign out_load = cmd.out_load;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    wheel_next = wheel;
    cmd        = '0;
    cmd.wheel  = wheel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cmd.clr    = 1'b1;
          cnt_next   = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = cnt[3:0];
        cnt_next   = cnt + 5'd1;
        if (cnt[3:0] == omwp_pkg::OP_DR) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_MAX;
      S_MAX: begin
        cmd.find_max = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        wheel_next = '0;
        state_next = sts.below ? S_DONE : S_DIVI;
      end
      S_DIVI: begin
        cmd.div_start = 1'b1;
        cnt_next      = '0;
        state_next    = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 5'd1;
        if (cnt == 5'd23) state_next = S_DIVQ;
      end
      S_DIVQ: begin
        cmd.div_store = 1'b1;
        if (wheel == 2'd2) begin
          cnt_next   = '0;
          state_next = S_SCALE;
        end else begin
          wheel_next = wheel + 2'd1;
          state_next = S_DIVI;
        end
      end
      S_SCALE: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = cnt[0] ? omwp_pkg::OP_AC : omwp_pkg::OP_SP;
        cmd.wheel  = cnt[2:1];
        cnt_next   = cnt + 5'd1;
        if (cnt == 5'd5) state_next = S_SDRAIN;
      end
      S_SDRAIN: state_next = S_DONE;
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      wheel     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      wheel <= wheel_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

@@ hdl/omwp_datapath.sv @@
// ----------------------------------------------------------------------------
// omwp_datapath
// Pose registers, shared multiplier, step accumulators, share divider and
// output registers.
// ----------------------------------------------------------------------------
module omwp_datapath #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  omwp_pkg::cmd_t      cmd,
  output omwp_pkg::sts_t      sts,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic signed [23:0]  target_x,
  input  logic signed [23:0]  target_y,
  input  logic signed [23:0]  target_heading,
  output logic signed [24:0]  wheel1_steps,
  output logic signed [24:0]  wheel2_steps,
  output logic signed [24:0]  wheel3_steps,
  output logic [23:0]         wheel1_speed,
  output logic [23:0]         wheel2_speed,
  output logic [23:0]         wheel3_speed,
  output logic [23:0]         wheel1_accel,
  output logic [23:0]         wheel2_accel,
  output logic [23:0]         wheel3_accel,
  output logic                moved
);

  localparam int P  = POSITION_WIDTH;
  localparam int DW = ((P > 24) ? P : 24) + 1;
  localparam int AW = DW + 1;
  localparam int BW = 34;
  localparam int PW = AW + BW;
  localparam int SW = DW + 39;
  localparam int RW = SW - 31;

  logic [15:0]        xs, ys, sd, g3, ts, ta;
  logic signed [15:0] dg;

  logic signed [23:0]  tx, ty, th;
  logic signed [P-1:0] pos_x, pos_y, pos_h;
  logic signed [DW-1:0] dx, dy, dr, txw, tyw, thw;
  logic [DW-1:0]        adx;

  logic signed [AW-1:0] ma;
  logic signed [BW-1:0] mb;
  logic signed [PW-1:0] prod;
  logic [3:0]           prod_op;
  logic [1:0]           prod_wheel;
  logic                 prod_vld;
  logic signed [SW-1:0] pext;
  logic [32:0]          c1, c2;
  logic signed [32:0]   c3;

  logic signed [SW-1:0] s1, s2, s3;
  logic [SW-1:0]        m [3];
  logic [SW-1:0]        big;
  logic [SW:0]          rem, rem2;
  logic [24:0]          q;
  logic                 full;
  logic [24:0]          qv [3];
  logic [23:0]          spd [3];
  logic [23:0]          acl [3];
  logic [24:0]          scl;
  logic [23:0]          scl_sat;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      xs <= 16'd20480;
      ys <= 16'd20480;
      sd <= 16'd2560;
      dg <= '0;
      g3 <= 16'd16384;
      ts <= 16'd1000;
      ta <= 16'd500;
    end else if (cfg_we) begin
      case (cfg_index)
        omwp_pkg::REG_XS: xs <= cfg_data;
        omwp_pkg::REG_YS: ys <= cfg_data;
        omwp_pkg::REG_SD: sd <= cfg_data;
        omwp_pkg::REG_DG: dg <= cfg_data;
        omwp_pkg::REG_G3: g3 <= cfg_data;
        omwp_pkg::REG_TS: ts <= cfg_data;
        omwp_pkg::REG_TA: ta <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tx <= target_x;
      ty <= target_y;
      th <= target_heading;
    end
  end

  assign txw = {{(DW-24){tx[23]}}, tx};
  assign tyw = {{(DW-24){ty[23]}}, ty};
  assign thw = {{(DW-24){th[23]}}, th};
  assign dx  = txw - {{(DW-P){pos_x[P-1]}}, pos_x};
  assign dy  = tyw - {{(DW-P){pos_y[P-1]}}, pos_y};
  assign dr  = thw - {{(DW-P){pos_h[P-1]}}, pos_h};
  assign adx = dx[DW-1] ? -dx : dx;

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_op)
      omwp_pkg::OP_XK: begin
        ma = {{(AW-16){1'b0}}, xs};
        mb = {{(BW-17){1'b0}}, omwp_pkg::COS30};
      end
      omwp_pkg::OP_XG: begin
        ma = {{(AW-16){1'b0}}, xs};
        mb = {{(BW-16){1'b0}}, g3};
      end
      omwp_pkg::OP_GY: begin
        ma = {{(AW-16){dg[15]}}, dg};
        mb = {{(BW-16){1'b0}}, ys};
      end
      omwp_pkg::OP_TX: begin
        ma = {dx[DW-1], dx};
        mb = {1'b0, c1};
      end
      omwp_pkg::OP_T3: begin
        ma = {dx[DW-1], dx};
        mb = {1'b0, c2};
      end
      omwp_pkg::OP_DY: begin
        ma = {dy[DW-1], dy};
        mb = {{(BW-16){1'b0}}, ys};
      end
      omwp_pkg::OP_DD: begin
        ma = {1'b0, adx};
        mb = {c3[32], c3};
      end
      omwp_pkg::OP_DR: begin
        ma = {dr[DW-1], dr};
        mb = {{(BW-16){1'b0}}, sd};
      end
      omwp_pkg::OP_SP: begin
        ma = {{(AW-25){1'b0}}, qv[cmd.wheel]};
        mb = {{(BW-16){1'b0}}, ts};
      end
      omwp_pkg::OP_AC: begin
        ma = {{(AW-25){1'b0}}, qv[cmd.wheel]};
        mb = {{(BW-16){1'b0}}, ta};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) prod_vld <= 1'b0;
    else     prod_vld <= cmd.mul_go;
  end

  always_ff @(posedge clk) begin
    prod       <= ma * mb;
    prod_op    <= cmd.mul_op;
    prod_wheel <= cmd.wheel;
  end

  assign pext    = {{(SW-PW){prod[PW-1]}}, prod};
  assign scl     = prod[40:16];
  assign scl_sat = (scl < {1'b0, omwp_pkg::FLOOR_Q8}) ? omwp_pkg::FLOOR_Q8 : scl[23:0];

  // fold each product into the wheel sums, or keep it as a coefficient or a scaled speed/accel
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
    end else if (prod_vld) begin
      case (prod_op)
        omwp_pkg::OP_XK: c1 <= prod[32:0];
        omwp_pkg::OP_XG: c2 <= prod[32:0];
        omwp_pkg::OP_GY: c3 <= prod[32:0];
        omwp_pkg::OP_TX: begin
          s1 <= s1 - pext;
          s2 <= s2 - pext;
        end
        omwp_pkg::OP_T3: s3 <= s3 - (pext <<< 2);
        omwp_pkg::OP_DY: begin
          s1 <= s1 + (pext <<< 15);
          s2 <= s2 - (pext <<< 15);
        end
        omwp_pkg::OP_DD: begin
          s1 <= s1 + pext;
          s2 <= s2 - pext;
        end
        omwp_pkg::OP_DR: begin
          s1 <= s1 - (pext <<< 16);
          s2 <= s2 - (pext <<< 16);
          s3 <= s3 + (pext <<< 16);
        end
        omwp_pkg::OP_SP: spd[prod_wheel] <= scl_sat;
        omwp_pkg::OP_AC: acl[prod_wheel] <= scl_sat;
        default: ;
      endcase
    end
  end

  assign m[0] = s1[SW-1] ? -s1 : s1;
  assign m[1] = s2[SW-1] ? -s2 : s2;
  assign m[2] = s3[SW-1] ? -s3 : s3;

  always_ff @(posedge clk) begin
    if (cmd.find_max) begin
      if (m[0] >= m[1] && m[0] >= m[2]) big <= m[0];
      else if (m[1] >= m[2])            big <= m[1];
      else                              big <= m[2];
    end
  end

  assign sts.below = (big < {{(SW-32){1'b0}}, omwp_pkg::THRESH});

  // restoring division, one quotient bit per cycle
  assign rem2 = {rem[SW-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem  <= {1'b0, m[cmd.wheel]};
      q    <= '0;
      full <= (m[cmd.wheel] >= big);
    end else if (cmd.div_step) begin
      if (rem2 >= {1'b0, big}) begin
        rem <= rem2 - {1'b0, big};
        q   <= {q[23:0], 1'b1};
      end else begin
        rem <= rem2;
        q   <= {q[23:0], 1'b0};
      end
    end
    if (cmd.div_store) qv[cmd.wheel] <= full ? omwp_pkg::SHARE_ONE : q;
  end

  function automatic logic [24:0] round_sat(input logic signed [SW-1:0] s,
                                            input logic [SW-1:0] mg);
    logic [SW:0]   t;
    logic [RW-1:0] r;
    logic [24:0]   v;
    t = {1'b0, mg} + ((SW+1)'(1) << 31);
    r = t[SW:32];
    if (s[SW-1]) begin
      if (r > RW'(25'h1000000)) v = 25'h1000000;
      else                      v = -r[24:0];
    end else begin
      if (r > RW'(25'h0FFFFFF)) v = 25'h0FFFFFF;
      else                      v = r[24:0];
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sts.below) begin
        wheel1_steps <= '0;
        wheel2_steps <= '0;
        wheel3_steps <= '0;
        wheel1_speed <= omwp_pkg::FLOOR_Q8;
        wheel2_speed <= omwp_pkg::FLOOR_Q8;
        wheel3_speed <= omwp_pkg::FLOOR_Q8;
        wheel1_accel <= omwp_pkg::FLOOR_Q8;
        wheel2_accel <= omwp_pkg::FLOOR_Q8;
        wheel3_accel <= omwp_pkg::FLOOR_Q8;
        moved        <= 1'b0;
      end else begin
        wheel1_steps <= round_sat(s1, m[0]);
        wheel2_steps <= round_sat(s2, m[1]);
        wheel3_steps <= round_sat(s3, m[2]);
        wheel1_speed <= spd[0];
        wheel2_speed <= spd[1];
        wheel3_speed <= spd[2];
        wheel1_accel <= acl[0];
        wheel2_accel <= acl[1];
        wheel3_accel <= acl[2];
        moved        <= 1'b1;
      end
    end
  end

  // pose follows the target only when a move was planned
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_h <= '0;
    end else if (cmd.out_load && !sts.below) begin
      pos_x <= txw[P-1:0];
      pos_y <= tyw[P-1:0];
      pos_h <= thw[P-1:0];
    end
  end

endmodule

@@ hdl/omwp_checker.sv @@
// ----------------------------------------------------------------------------
// omwp_checker
// Port-level checks of the move planner, bound to the top level.
// ----------------------------------------------------------------------------
module omwp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [24:0] wheel1_steps,
  input logic signed [24:0] wheel2_steps,
  input logic signed [24:0] wheel3_steps,
  input logic [23:0]        wheel1_speed,
  input logic [23:0]        wheel2_speed,
  input logic [23:0]        wheel3_speed,
  input logic [23:0]        wheel1_accel,
  input logic [23:0]        wheel2_accel,
  input logic [23:0]        wheel3_accel,
  input logic               moved
);

  // a held result stays until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // one target in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second target taken while busy");

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !moved |-> wheel1_steps == 0 && wheel2_steps == 0 &&
      wheel3_steps == 0 && wheel1_speed == 24'd256 && wheel2_accel == 24'd256)
    else $error("no-move result carries motion");

  a_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> wheel1_speed >= 24'd256 && wheel2_speed >= 24'd256 &&
      wheel3_speed >= 24'd256 && wheel1_accel >= 24'd256 &&
      wheel3_accel >= 24'd256)
    else $error("speed or accel below floor");

endmodule

bind omni_wheel_move_planner omwp_checker u_omwp_checker (.*);
